// File: rtl/bmte_pkg.sv
`default_nettype none

package bmte_pkg;

    // command kinds
    localparam logic [3:0] KIND_SIZE      = 4'd0;
    localparam logic [3:0] KIND_WRITE     = 4'd1;
    localparam logic [3:0] KIND_READ      = 4'd2;
    localparam logic [3:0] KIND_SWAPCELL  = 4'd3;
    localparam logic [3:0] KIND_SWAPROW   = 4'd4;
    localparam logic [3:0] KIND_SWAPCOL   = 4'd5;
    localparam logic [3:0] KIND_REVROW    = 4'd6;
    localparam logic [3:0] KIND_REVCOL    = 4'd7;
    localparam logic [3:0] KIND_MIRRORLR  = 4'd8;
    localparam logic [3:0] KIND_MIRRORTB  = 4'd9;
    localparam logic [3:0] KIND_ROTATE    = 4'd10;
    localparam logic [3:0] KIND_TRANSPOSE = 4'd11;

    // datapath micro-steps
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_RD_A,
        DP_RD_B,
        DP_WR_A,
        DP_WR_B,
        DP_WRITE,
        DP_CP_RD,
        DP_CP_WR,
        DP_MV_RD,
        DP_MV_WR
    } t_dp_step;

    typedef struct packed {
        t_dp_step   step;
        logic [7:0] value;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] rdata;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/byte_matrix_transform_engine.sv
// Byte matrix transform engine.
// Commands arrive on the slave stream, one per transaction; each gives
// exactly one result transaction on the master stream.
// Slave tdata: kind, row_a, col_a, row_b, col_b, value (low bits first).
// Master tdata: ok, read_value.
// Swap-type commands run a sequencer over the cell pairs; each pair is read
// (RD_A, RD_B) and written back swapped (WR_A, WR_B). Rotation copies the
// active region into the scratch store and moves it back, cell by cell.
// One command is worked at a time; tready is high only while idle.
// A finished result sits in the output register; the next command is
// accepted meanwhile, and its own result waits until the register frees.
// Reset clears the shape to 0 x 0 and the output valid flag; cell contents are kept
// undefined until written.
`default_nettype none

module byte_matrix_transform_engine
    import bmte_pkg::*;
#(
    parameter int MATRIX_DIM = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // kind[3:0], row_a[7:4], col_a[11:8], row_b[15:12], col_b[19:16],
    // value[27:20], zero fill
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // ok[0], read_value[8:1], zero fill
    output logic [15:0]      m_axis_tdata
);

    localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    // sequencer
    bmte_controller #(
        .MATRIX_DIM (MATRIX_DIM),
        .AW         (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_cmd      (cmd),
        .o_addr_a   (addr_a),
        .o_addr_b   (addr_b),
        .i_status   (status)
    );

    // cell and scratch stores
    bmte_datapath #(
        .MATRIX_DIM (MATRIX_DIM),
        .AW         (AW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_addr_a (addr_a),
        .i_addr_b (addr_b),
        .o_status (status)
    );

endmodule

`default_nettype wire

// File: rtl/bmte_datapath.sv
`default_nettype none

module bmte_datapath
    import bmte_pkg::*;
#(
    parameter int MATRIX_DIM = 16,
    parameter int AW         = 8
) (
    input  wire logic          i_clk,
    input  wire t_dp_cmd       i_cmd,
    input  wire logic [AW-1:0] i_addr_a,
    input  wire logic [AW-1:0] i_addr_b,
    output t_dp_status         o_status
);

    localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;

    logic [7:0] r_cells   [DEPTH];
    logic [7:0] r_scratch [DEPTH];
    logic [7:0] r_cell_q;
    logic [7:0] r_scr_q;
    logic [7:0] r_tmp;

    logic          cell_we;
    logic [AW-1:0] cell_waddr;
    logic [7:0]    cell_wdata;
    logic [AW-1:0] cell_raddr;

    // write and read port selection for the cell store
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = i_addr_a;
        cell_wdata = r_cell_q;
        cell_raddr = i_addr_a;
        case (i_cmd.step)
            DP_RD_B: begin
                cell_raddr = i_addr_b;
            end
            DP_WR_A: begin
                cell_we = 1'b1;
            end
            DP_WR_B: begin
                cell_we    = 1'b1;
                cell_waddr = i_addr_b;
                cell_wdata = r_tmp;
            end
            DP_WRITE: begin
                cell_we    = 1'b1;
                cell_wdata = i_cmd.value;
            end
            DP_MV_WR: begin
                cell_we    = 1'b1;
                cell_waddr = i_addr_b;
                cell_wdata = r_scr_q;
            end
            default: begin
            end
        endcase
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cells[cell_waddr] <= cell_wdata;
        end
        if (i_cmd.step == DP_RD_A || i_cmd.step == DP_RD_B || i_cmd.step == DP_CP_RD) begin
            r_cell_q <= r_cells[cell_raddr];
        end
        if (i_cmd.step == DP_RD_B) begin
            r_tmp <= r_cell_q;
        end
    end

    // scratch store used by rotation
    always_ff @(posedge i_clk) begin
        if (i_cmd.step == DP_CP_WR) begin
            r_scratch[i_addr_a] <= r_cell_q;
        end
        if (i_cmd.step == DP_MV_RD) begin
            r_scr_q <= r_scratch[i_addr_a];
        end
    end

    assign o_status.rdata = r_cell_q;

endmodule

`default_nettype wire

// File: rtl/bmte_controller.sv
`default_nettype none

module bmte_controller
    import bmte_pkg::*;
#(
    parameter int MATRIX_DIM = 16,
    parameter int AW         = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [31:0]   i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [15:0]        o_m_tdata,
    output t_dp_cmd            o_cmd,
    output logic [AW-1:0]      o_addr_a,
    output logic [AW-1:0]      o_addr_b,
    input  wire t_dp_status    i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_WRITE,
        S_READ_RD,
        S_READ_WAIT,
        S_CP_RD,
        S_CP_WR,
        S_MV_RD,
        S_MV_WR,
        S_DONE
    } t_state;

    t_state     r_state;
    logic [3:0] r_kind;
    logic [3:0] r_ra;
    logic [3:0] r_ca;
    logic [3:0] r_rb;
    logic [3:0] r_cb;
    logic [7:0] r_value;
    logic [3:0] r_row_cnt;
    logic [3:0] r_col_cnt;
    logic [4:0] r_i;
    logic [4:0] r_j;
    logic       r_phase;
    logic       r_ok;
    logic [7:0] r_rv;
    logic       r_m_valid;
    logic [15:0] r_m_data;

    // input fields
    logic [3:0] in_kind, in_ra, in_ca, in_rb, in_cb;
    logic [7:0] in_value;
    logic       s_acc, a_ok, b_ok, in_ok, m_free;

    assign in_kind  = i_s_tdata[3:0];
    assign in_ra    = i_s_tdata[7:4];
    assign in_ca    = i_s_tdata[11:8];
    assign in_rb    = i_s_tdata[15:12];
    assign in_cb    = i_s_tdata[19:16];
    assign in_value = i_s_tdata[27:20];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_free     = !r_m_valid || i_m_tready;
    assign a_ok       = (in_ra < r_row_cnt) && (in_ca < r_col_cnt);
    assign b_ok       = (in_rb < r_row_cnt) && (in_cb < r_col_cnt);

    // validity of a command against the current shape (size: against MATRIX_DIM)
    always_comb begin
        case (in_kind)
            KIND_SIZE:      in_ok = (32'(in_ra) < MATRIX_DIM) && (32'(in_ca) < MATRIX_DIM);
            KIND_WRITE:     in_ok = a_ok;
            KIND_READ:      in_ok = a_ok;
            KIND_SWAPCELL:  in_ok = a_ok && b_ok;
            KIND_SWAPROW:   in_ok = (in_ra < r_row_cnt) && (in_rb < r_row_cnt);
            KIND_SWAPCOL:   in_ok = (in_ca < r_col_cnt) && (in_cb < r_col_cnt);
            KIND_REVROW:    in_ok = (in_ra < r_row_cnt);
            KIND_REVCOL:    in_ok = (in_ca < r_col_cnt);
            KIND_MIRRORLR:  in_ok = 1'b1;
            KIND_MIRRORTB:  in_ok = 1'b1;
            KIND_ROTATE:    in_ok = 1'b1;
            KIND_TRANSPOSE: in_ok = (r_row_cnt == r_col_cnt);
            default:        in_ok = 1'b0;
        endcase
    end

    // loop bounds and the cell pair for the current iteration
    logic [4:0] rc, cc, ob, ib, is_next;
    logic [4:0] ar, ac, br, bc;

    assign rc = {1'b0, r_row_cnt};
    assign cc = {1'b0, r_col_cnt};

    always_comb begin
        ob      = 5'd1;
        ib      = 5'd1;
        is_next = 5'd0;
        ar      = {1'b0, r_ra};
        ac      = {1'b0, r_ca};
        br      = {1'b0, r_rb};
        bc      = {1'b0, r_cb};
        case (r_kind)
            KIND_SWAPROW: begin
                ib = cc;
                ac = r_j;
                bc = r_j;
            end
            KIND_SWAPCOL: begin
                ib = rc;
                ar = r_j;
                br = r_j;
            end
            KIND_REVROW: begin
                ib = cc >> 1;
                br = {1'b0, r_ra};
                ac = r_j;
                bc = cc - 5'd1 - r_j;
            end
            KIND_REVCOL: begin
                ib = rc >> 1;
                bc = {1'b0, r_ca};
                ar = r_j;
                br = rc - 5'd1 - r_j;
            end
            KIND_MIRRORLR: begin
                ob = cc >> 1;
                ib = rc;
                ar = r_j;
                ac = r_i;
                br = r_j;
                bc = cc - 5'd1 - r_i;
            end
            KIND_MIRRORTB: begin
                ob = rc >> 1;
                ib = cc;
                ar = r_i;
                ac = r_j;
                br = rc - 5'd1 - r_i;
                bc = r_j;
            end
            KIND_TRANSPOSE: begin
                ob      = rc;
                ib      = cc;
                is_next = r_i + 5'd2;
                ar      = r_i;
                ac      = r_j;
                br      = r_j;
                bc      = r_i;
            end
            KIND_ROTATE: begin
                ob = rc;
                ib = cc;
                ar = r_i;
                ac = r_j;
                br = r_j;
                bc = rc - 5'd1 - r_i;
            end
            default: begin
            end
        endcase
    end

    // row-major addresses
    assign o_addr_a = AW'(32'(ar) * MATRIX_DIM + 32'(ac));
    assign o_addr_b = AW'(32'(br) * MATRIX_DIM + 32'(bc));

    // datapath step follows the state
    always_comb begin
        o_cmd.value = r_value;
        case (r_state)
            S_RD_A:    o_cmd.step = DP_RD_A;
            S_RD_B:    o_cmd.step = DP_RD_B;
            S_WR_A:    o_cmd.step = DP_WR_A;
            S_WR_B:    o_cmd.step = DP_WR_B;
            S_WRITE:   o_cmd.step = DP_WRITE;
            S_READ_RD: o_cmd.step = DP_RD_A;
            S_CP_RD:   o_cmd.step = DP_CP_RD;
            S_CP_WR:   o_cmd.step = DP_CP_WR;
            S_MV_RD:   o_cmd.step = DP_MV_RD;
            S_MV_WR:   o_cmd.step = DP_MV_WR;
            default:   o_cmd.step = DP_IDLE;
        endcase
    end

    // state, shape and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_cnt <= 4'd0;
            r_col_cnt <= 4'd0;
            r_m_valid <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            // output valid flag
            if (r_state == S_DONE && m_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_kind  <= in_kind;
                        r_ra    <= in_ra;
                        r_ca    <= in_ca;
                        r_rb    <= in_rb;
                        r_cb    <= in_cb;
                        r_value <= in_value;
                        r_ok    <= in_ok;
                        r_rv    <= 8'd0;
                        r_i     <= 5'd0;
                        r_j     <= (in_kind == KIND_TRANSPOSE) ? 5'd1 : 5'd0;
                        r_phase <= 1'b0;
                        if (!in_ok) begin
                            r_state <= S_DONE;
                        end else if (in_kind == KIND_SIZE) begin
                            r_row_cnt <= in_ra;
                            r_col_cnt <= in_ca;
                            r_state   <= S_DONE;
                        end else if (in_kind == KIND_WRITE) begin
                            r_state <= S_WRITE;
                        end else if (in_kind == KIND_READ) begin
                            r_state <= S_READ_RD;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_i >= ob) begin
                        if (r_kind == KIND_ROTATE && !r_phase) begin
                            r_phase <= 1'b1;
                            r_i     <= 5'd0;
                            r_j     <= 5'd0;
                        end else begin
                            if (r_kind == KIND_ROTATE) begin
                                r_row_cnt <= r_col_cnt;
                                r_col_cnt <= r_row_cnt;
                            end
                            r_state <= S_DONE;
                        end
                    end else if (r_j >= ib) begin
                        r_i <= r_i + 5'd1;
                        r_j <= is_next;
                    end else if (r_kind == KIND_ROTATE) begin
                        r_state <= r_phase ? S_MV_RD : S_CP_RD;
                    end else begin
                        r_state <= S_RD_A;
                    end
                end
                S_RD_A:  r_state <= S_RD_B;
                S_RD_B:  r_state <= S_WR_A;
                S_WR_A:  r_state <= S_WR_B;
                S_WR_B: begin
                    r_j     <= r_j + 5'd1;
                    r_state <= S_CHECK;
                end
                S_CP_RD: r_state <= S_CP_WR;
                S_MV_RD: r_state <= S_MV_WR;
                S_CP_WR, S_MV_WR: begin
                    r_j     <= r_j + 5'd1;
                    r_state <= S_CHECK;
                end
                S_WRITE:   r_state <= S_DONE;
                S_READ_RD: r_state <= S_READ_WAIT;
                S_READ_WAIT: begin
                    r_rv    <= i_status.rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (m_free) begin
                        r_m_data <= {7'd0, r_rv, r_ok};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

// File: sim/byte_matrix_transform_engine_tb.sv
`default_nettype none

module byte_matrix_transform_engine_tb;
    import bmte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM       = 16;
    localparam int WDOG_MAX  = 40000;
    localparam int N_RANDOM  = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // kind, row_a, col_a, row_b, col_b, value, zero fill
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // ok, read_value, zero fill
    logic [15:0] m_axis_tdata;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] row_a;
        logic [3:0] col_a;
        logic [3:0] row_b;
        logic [3:0] col_b;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [7:0] read_value;
    } t_reply;

    // directed row: command plus optional typed-in answer
    typedef struct packed {
        t_cmd   cmd;
        logic   fixed;
        t_reply reply;
    } t_row;

    // shadow matrix state
    logic [7:0] shadow_cells [DIM*DIM];
    logic       shadow_valid [DIM*DIM];
    int         shadow_rows;
    int         shadow_cols;

    t_reply     pending_replies[$];
    int         fail_count = 0;
    int         table_fails;
    int         wdog;
    bit         quiet_out;

    byte_matrix_transform_engine #(.MATRIX_DIM(DIM)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int cell_ix(int r, int c);
        return (r * DIM + c) % (DIM * DIM);
    endfunction

    function automatic void swap_cells(int r1, int c1, int r2, int c2);
        logic [7:0] t;
        logic       tv;
        t  = shadow_cells[cell_ix(r1, c1)];
        tv = shadow_valid[cell_ix(r1, c1)];
        shadow_cells[cell_ix(r1, c1)] = shadow_cells[cell_ix(r2, c2)];
        shadow_valid[cell_ix(r1, c1)] = shadow_valid[cell_ix(r2, c2)];
        shadow_cells[cell_ix(r2, c2)] = t;
        shadow_valid[cell_ix(r2, c2)] = tv;
    endfunction

    // apply one command to the shadow matrix and give its reply
    function automatic t_reply matrix_apply(t_cmd cmd);
        t_reply     rep;
        int         ra, ca, rb, cb, tmp;
        bit         a_ok, b_ok;
        logic [7:0] copy_c [DIM*DIM];
        logic       copy_v [DIM*DIM];
        ra = cmd.row_a; ca = cmd.col_a; rb = cmd.row_b; cb = cmd.col_b;
        a_ok = ra < shadow_rows && ca < shadow_cols;
        b_ok = rb < shadow_rows && cb < shadow_cols;
        rep = '0;
        case (cmd.kind)
            KIND_SIZE: begin
                if (ra < DIM && ca < DIM) begin
                    shadow_rows = ra; shadow_cols = ca; rep.ok = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (a_ok) begin
                    shadow_cells[cell_ix(ra, ca)] = cmd.value;
                    shadow_valid[cell_ix(ra, ca)] = 1'b1;
                    rep.ok = 1'b1;
                end
            end
            KIND_READ: begin
                if (a_ok) begin
                    rep.read_value = shadow_cells[cell_ix(ra, ca)];
                    rep.ok = 1'b1;
                end
            end
            KIND_SWAPCELL: begin
                if (a_ok && b_ok) begin
                    swap_cells(ra, ca, rb, cb); rep.ok = 1'b1;
                end
            end
            KIND_SWAPROW: begin
                if (ra < shadow_rows && rb < shadow_rows) begin
                    for (int c = 0; c < shadow_cols; c++) swap_cells(ra, c, rb, c);
                    rep.ok = 1'b1;
                end
            end
            KIND_SWAPCOL: begin
                if (ca < shadow_cols && cb < shadow_cols) begin
                    for (int r = 0; r < shadow_rows; r++) swap_cells(r, ca, r, cb);
                    rep.ok = 1'b1;
                end
            end
            KIND_REVROW: begin
                if (ra < shadow_rows) begin
                    for (int i = 0; i < shadow_cols / 2; i++)
                        swap_cells(ra, i, ra, shadow_cols - 1 - i);
                    rep.ok = 1'b1;
                end
            end
            KIND_REVCOL: begin
                if (ca < shadow_cols) begin
                    for (int i = 0; i < shadow_rows / 2; i++)
                        swap_cells(i, ca, shadow_rows - 1 - i, ca);
                    rep.ok = 1'b1;
                end
            end
            KIND_MIRRORLR: begin
                for (int i = 0; i < shadow_cols / 2; i++)
                    for (int r = 0; r < shadow_rows; r++)
                        swap_cells(r, i, r, shadow_cols - 1 - i);
                rep.ok = 1'b1;
            end
            KIND_MIRRORTB: begin
                for (int i = 0; i < shadow_rows / 2; i++)
                    for (int c = 0; c < shadow_cols; c++)
                        swap_cells(i, c, shadow_rows - 1 - i, c);
                rep.ok = 1'b1;
            end
            KIND_ROTATE: begin
                copy_c = shadow_cells;
                copy_v = shadow_valid;
                for (int r = 0; r < shadow_rows; r++)
                    for (int c = 0; c < shadow_cols; c++) begin
                        shadow_cells[cell_ix(c, shadow_rows - 1 - r)] = copy_c[cell_ix(r, c)];
                        shadow_valid[cell_ix(c, shadow_rows - 1 - r)] = copy_v[cell_ix(r, c)];
                    end
                tmp = shadow_rows; shadow_rows = shadow_cols; shadow_cols = tmp;
                rep.ok = 1'b1;
            end
            KIND_TRANSPOSE: begin
                if (shadow_rows == shadow_cols) begin
                    for (int r = 0; r < shadow_rows; r++)
                        for (int c = r + 1; c < shadow_cols; c++) swap_cells(r, c, c, r);
                    rep.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // a read in range is only legal on a written cell; the caller drops it otherwise
    function automatic bit read_is_safe(t_cmd cmd);
        if (cmd.kind != KIND_READ) return 1'b1;
        if (cmd.row_a >= shadow_rows || cmd.col_a >= shadow_cols) return 1'b1;
        return shadow_valid[cell_ix(cmd.row_a, cmd.col_a)];
    endfunction

    // random command, mostly in range of the current shape
    function automatic t_cmd random_cmd();
        t_cmd cmd;
        int   rmax, cmax, pick;
        cmd = '0;
        rmax = (shadow_rows > 0) ? shadow_rows - 1 : 0;
        cmax = (shadow_cols > 0) ? shadow_cols - 1 : 0;
        pick = $urandom_range(0, 99);
        if (pick < 8)       cmd.kind = KIND_SIZE;
        else if (pick < 40) cmd.kind = KIND_WRITE;
        else if (pick < 55) cmd.kind = KIND_READ;
        else if (pick < 96) cmd.kind = 4'($urandom_range(KIND_SWAPCELL, KIND_TRANSPOSE));
        else                cmd.kind = 4'($urandom_range(12, 15));
        cmd.value = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            cmd.row_a = 4'($urandom); cmd.col_a = 4'($urandom);
            cmd.row_b = 4'($urandom); cmd.col_b = 4'($urandom);
        end else begin
            cmd.row_a = 4'($urandom_range(0, rmax)); cmd.col_a = 4'($urandom_range(0, cmax));
            cmd.row_b = 4'($urandom_range(0, rmax)); cmd.col_b = 4'($urandom_range(0, cmax));
        end
        if (cmd.kind == KIND_SIZE) begin
            // small shapes mostly, square often so transpose works
            if ($urandom_range(0, 5) == 0) begin
                cmd.row_a = 4'($urandom); cmd.col_a = 4'($urandom);
            end else begin
                cmd.row_a = 4'($urandom_range(0, 6));
                cmd.col_a = ($urandom_range(0, 1)) ? cmd.row_a : 4'($urandom_range(0, 6));
            end
        end
        return cmd;
    endfunction

    // send one command transaction, predicting its reply
    task automatic send_cmd(t_cmd cmd, bit fixed, t_reply want, bit quiet);
        t_reply pred;
        while (!quiet && $urandom_range(0, 99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pred = matrix_apply(cmd);
        if (fixed && pred !== want) begin
            $display("%0t table row mismatch: expected %h actual %h", $realtime, want, pred);
            table_fails++;
        end
        pending_replies.push_back(fixed ? want : pred);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cmd.value, cmd.col_b, cmd.row_b, cmd.col_a, cmd.row_a,
                          cmd.kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // reply checker and output stalls
    always @(posedge i_clk) begin
        t_reply got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ok         = m_axis_tdata[0];
                got.read_value = m_axis_tdata[8:1];
                if (pending_replies.size() == 0) begin
                    $display("%0t unexpected reply: expected none actual ok=%b rv=%h",
                             $realtime, got.ok, got.read_value);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.ok !== want.ok) begin
                        $display("%0t ok mismatch: expected %b actual %b",
                                 $realtime, want.ok, got.ok);
                        fail_count++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t read_value mismatch: expected %h actual %h",
                                 $realtime, want.read_value, got.read_value);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= quiet_out || ($urandom_range(0, 99) >= 37);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    t_row dir_rows[$];

    function automatic t_cmd mk(logic [3:0] k, int ra, int ca, int rb, int cb, int v);
        t_cmd c;
        c.kind = k; c.row_a = 4'(ra); c.col_a = 4'(ca);
        c.row_b = 4'(rb); c.col_b = 4'(cb); c.value = 8'(v);
        return c;
    endfunction

    task automatic add_row(t_cmd c, bit fixed, bit ok, int rv);
        t_row r;
        r.cmd = c; r.fixed = fixed; r.reply.ok = ok; r.reply.read_value = 8'(rv);
        dir_rows.push_back(r);
    endtask

    initial begin
        t_cmd cmd;
        int   n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        table_fails   = 0;
        quiet_out     = 1'b0;
        shadow_rows   = 0;
        shadow_cols   = 0;
        for (int i = 0; i < DIM*DIM; i++) begin
            shadow_cells[i] = '0; shadow_valid[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(mk(KIND_WRITE, 0, 0, 0, 0, 8'h11), 1, 0, 0);     // empty after reset
        add_row(mk(KIND_MIRRORLR, 0, 0, 0, 0, 0), 1, 1, 0);      // mirror of empty
        add_row(mk(KIND_ROTATE, 0, 0, 0, 0, 0), 1, 1, 0);
        add_row(mk(KIND_TRANSPOSE, 0, 0, 0, 0, 0), 1, 1, 0);     // 0 x 0 is square
        add_row(mk(KIND_SIZE, 15, 15, 0, 0, 0), 1, 1, 0);        // largest size
        add_row(mk(KIND_SIZE, 14, 15, 0, 0, 0), 1, 1, 0);
        add_row(mk(KIND_SIZE, 15, 15, 0, 0, 0), 1, 1, 0);
        add_row(mk(KIND_SIZE, 3, 4, 15, 15, 8'hff), 1, 1, 0);
        add_row(mk(KIND_WRITE, 0, 0, 0, 0, 8'h00), 1, 1, 0);
        add_row(mk(KIND_WRITE, 2, 3, 0, 0, 8'hff), 1, 1, 0);
        add_row(mk(KIND_WRITE, 3, 0, 0, 0, 8'h55), 1, 0, 0);     // row out of range
        add_row(mk(KIND_WRITE, 0, 4, 0, 0, 8'h55), 1, 0, 0);     // column out of range
        add_row(mk(KIND_READ, 2, 3, 0, 0, 0), 1, 1, 8'hff);
        add_row(mk(KIND_READ, 15, 15, 0, 0, 0), 1, 0, 0);
        add_row(mk(KIND_SWAPCELL, 0, 0, 2, 3, 0), 0, 0, 0);
        add_row(mk(KIND_SWAPCELL, 0, 0, 3, 3, 0), 1, 0, 0);
        add_row(mk(KIND_SWAPROW, 0, 0, 2, 0, 0), 0, 0, 0);
        add_row(mk(KIND_SWAPCOL, 0, 0, 0, 3, 0), 0, 0, 0);       // walks every row
        add_row(mk(KIND_REVROW, 2, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(KIND_REVCOL, 0, 3, 0, 0, 0), 0, 0, 0);
        add_row(mk(KIND_MIRRORTB, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(KIND_TRANSPOSE, 0, 0, 0, 0, 0), 1, 0, 0);     // non-square
        add_row(mk(KIND_ROTATE, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(4'd12, 0, 0, 0, 0, 0), 1, 0, 0);              // unknown kind
        add_row(mk(4'd15, 15, 15, 15, 15, 8'hff), 1, 0, 0);
        foreach (dir_rows[i]) begin
            cmd = dir_rows[i].cmd;
            if (read_is_safe(cmd)) send_cmd(cmd, dir_rows[i].fixed, dir_rows[i].reply, 1'b0);
        end

        // random part, with a quiet stretch in the middle
        n = 0;
        while (n < N_RANDOM) begin
            cmd = random_cmd();
            if (!read_is_safe(cmd)) continue;
            quiet_out = (n >= 200 && n < 260);
            send_cmd(cmd, 1'b0, '0, quiet_out);
            n++;
        end
        quiet_out = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && table_fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/bmte_pkg.sv
rtl/bmte_datapath.sv
rtl/bmte_controller.sv
rtl/byte_matrix_transform_engine.sv
sim/byte_matrix_transform_engine_tb.sv
